>>> src/tcbm_pkg.sv
// Shared types, codes and constants of the tile color background model.
// Holds the tile entry layout and the reciprocal table for the mean division.
// Depends on nothing.
`timescale 1ns / 1ps

package tcbm_pkg;

  // Tile store geometry.
  localparam int TILE_COUNT  = 4096;
  localparam int TILE_ADDR_W = 12;

  // Field widths.
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 14;
  localparam int COUNT_W = 7;

  // A tile stops accumulating once it holds this many pixels.
  localparam logic [COUNT_W-1:0] COUNT_CAP = 7'd64;

  // Reciprocal division: quotient = (sum * RECIP[n-1]) >> RECIP_SHIFT.
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int RecipNum    = (1 << RECIP_SHIFT) - 1;

  // Commands.
  localparam logic [1:0] CMD_CLEAR      = 2'd0;
  localparam logic [1:0] CMD_ACCUMULATE = 2'd1;
  localparam logic [1:0] CMD_FINALIZE   = 2'd2;
  localparam logic [1:0] CMD_CLASSIFY   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_DIFF_THRESHOLD = 1'b0;
  localparam logic CFG_MIN_COUNT      = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0]         DIFF_THRESHOLD_RESET = 8'd24;
  localparam logic [COUNT_W-1:0] MIN_COUNT_RESET      = 7'd32;

  // One entry of the tile store.
  typedef struct packed {
    logic [SUM_W-1:0]   sum_red;
    logic [SUM_W-1:0]   sum_green;
    logic [SUM_W-1:0]   sum_blue;
    logic [COUNT_W-1:0] count;
    logic [PIX_W-1:0]   mean_red;
    logic [PIX_W-1:0]   mean_green;
    logic [PIX_W-1:0]   mean_blue;
    logic               valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // ceil(2^20 / n) for n = 1..64, indexed by n - 1. Exact for sums below 2^14.
  localparam logic [RECIP_W-1:0] RECIP [64] = '{
    21'(RecipNum / 1 + 1),  21'(RecipNum / 2 + 1),  21'(RecipNum / 3 + 1),
    21'(RecipNum / 4 + 1),  21'(RecipNum / 5 + 1),  21'(RecipNum / 6 + 1),
    21'(RecipNum / 7 + 1),  21'(RecipNum / 8 + 1),  21'(RecipNum / 9 + 1),
    21'(RecipNum / 10 + 1), 21'(RecipNum / 11 + 1), 21'(RecipNum / 12 + 1),
    21'(RecipNum / 13 + 1), 21'(RecipNum / 14 + 1), 21'(RecipNum / 15 + 1),
    21'(RecipNum / 16 + 1), 21'(RecipNum / 17 + 1), 21'(RecipNum / 18 + 1),
    21'(RecipNum / 19 + 1), 21'(RecipNum / 20 + 1), 21'(RecipNum / 21 + 1),
    21'(RecipNum / 22 + 1), 21'(RecipNum / 23 + 1), 21'(RecipNum / 24 + 1),
    21'(RecipNum / 25 + 1), 21'(RecipNum / 26 + 1), 21'(RecipNum / 27 + 1),
    21'(RecipNum / 28 + 1), 21'(RecipNum / 29 + 1), 21'(RecipNum / 30 + 1),
    21'(RecipNum / 31 + 1), 21'(RecipNum / 32 + 1), 21'(RecipNum / 33 + 1),
    21'(RecipNum / 34 + 1), 21'(RecipNum / 35 + 1), 21'(RecipNum / 36 + 1),
    21'(RecipNum / 37 + 1), 21'(RecipNum / 38 + 1), 21'(RecipNum / 39 + 1),
    21'(RecipNum / 40 + 1), 21'(RecipNum / 41 + 1), 21'(RecipNum / 42 + 1),
    21'(RecipNum / 43 + 1), 21'(RecipNum / 44 + 1), 21'(RecipNum / 45 + 1),
    21'(RecipNum / 46 + 1), 21'(RecipNum / 47 + 1), 21'(RecipNum / 48 + 1),
    21'(RecipNum / 49 + 1), 21'(RecipNum / 50 + 1), 21'(RecipNum / 51 + 1),
    21'(RecipNum / 52 + 1), 21'(RecipNum / 53 + 1), 21'(RecipNum / 54 + 1),
    21'(RecipNum / 55 + 1), 21'(RecipNum / 56 + 1), 21'(RecipNum / 57 + 1),
    21'(RecipNum / 58 + 1), 21'(RecipNum / 59 + 1), 21'(RecipNum / 60 + 1),
    21'(RecipNum / 61 + 1), 21'(RecipNum / 62 + 1), 21'(RecipNum / 63 + 1),
    21'(RecipNum / 64 + 1)
  };

endpackage

>>> src/tcbm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module tcbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/tile_color_background_model_unit.sv
// Top level of the tile color background model: command sequencer, tile store,
// reciprocal divider and output register. Depends on tcbm_pkg and tcbm_ram.
//
//   channel   direction  handshake                 payload
//   request   in         in_valid / in_ready       command tile_index red green blue masked
//   result    out        out_valid / out_ready     foreground mean_red/green/blue tile_valid
//   config    in         cfg_write                 cfg_index cfg_data
//
// Clear, accumulate and classify read the store, then update and give the result;
// a finalize that yields a valid mean also runs the divide phases, as one shared
// multiplier divides the three channel sums in turn. A new request is taken only
// once the last one is done. After reset a clearing pass writes all 4096 tiles,
// one per cycle, with in_ready low; configuration writes are taken throughout.
// A result waits in the output register; a full register stalls only the
// request that wants to deliver the next result.
`timescale 1ns / 1ps

module tile_color_background_model_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Request channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [tcbm_pkg::TILE_ADDR_W-1:0]   tile_index,
  input  logic [tcbm_pkg::PIX_W-1:0]         red,
  input  logic [tcbm_pkg::PIX_W-1:0]         green,
  input  logic [tcbm_pkg::PIX_W-1:0]         blue,
  input  logic                               masked,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               foreground,
  output logic [tcbm_pkg::PIX_W-1:0]         mean_red,
  output logic [tcbm_pkg::PIX_W-1:0]         mean_green,
  output logic [tcbm_pkg::PIX_W-1:0]         mean_blue,
  output logic                               tile_valid,
  // Configuration port.
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [7:0]                         cfg_data
);

  import tcbm_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  localparam logic [1:0] PHASE_LAST = 2'd3;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [TILE_ADDR_W-1:0] clr_addr;
  logic [7:0]             diff_threshold;
  logic [COUNT_W-1:0]     min_count;

  // Latched request.
  logic [1:0]             cmd_q;
  logic [TILE_ADDR_W-1:0] tile_q;
  logic [PIX_W-1:0]       red_q;
  logic [PIX_W-1:0]       green_q;
  logic [PIX_W-1:0]       blue_q;
  logic                   masked_q;

  // Divider registers.
  logic [1:0]             phase;
  logic [RECIP_W-1:0]     recip_q;
  logic [PROD_W-1:0]      prod;
  logic [PIX_W-1:0]       quot_red;
  logic [PIX_W-1:0]       quot_green;
  logic [SUM_W-1:0]       sum_sel;
  logic [PIX_W-1:0]       prod_quot;

  // Store ports.
  logic                   mem_we;
  logic [TILE_ADDR_W-1:0] mem_waddr;
  entry_t                 mem_wdata;
  logic [ENTRY_W-1:0]     mem_rdata;
  entry_t                 cur;

  // Result of the current request.
  logic                   out_free;
  logic                   produce;
  logic                   res_fg;
  logic [PIX_W-1:0]       res_red;
  logic [PIX_W-1:0]       res_green;
  logic [PIX_W-1:0]       res_blue;
  logic                   res_valid;

  // Execute-stage helpers.
  logic                   fin_ok;
  logic [PIX_W-1:0]       diff_max;
  logic [PIX_W-1:0]       diff_r;
  logic [PIX_W-1:0]       diff_g;
  logic [PIX_W-1:0]       diff_b;
  logic [COUNT_W-2:0]     recip_idx;

  logic in_fire;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cur      = entry_t'(mem_rdata);

  tcbm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TILE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (tile_index),
    .rdata (mem_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= DIFF_THRESHOLD_RESET;
      min_count      <= MIN_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIFF_THRESHOLD: diff_threshold <= cfg_data;
        CFG_MIN_COUNT:      min_count      <= cfg_data[COUNT_W-1:0];
        default:            diff_threshold <= diff_threshold;
      endcase
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q    <= command;
      tile_q   <= tile_index;
      red_q    <= red;
      green_q  <= green;
      blue_q   <= blue;
      masked_q <= masked;
    end
  end

  // Classification distance and finalize check on the stored entry.
  assign diff_r    = abs_diff(red_q, cur.mean_red);
  assign diff_g    = abs_diff(green_q, cur.mean_green);
  assign diff_b    = abs_diff(blue_q, cur.mean_blue);
  assign fin_ok    = (cur.count != '0) && (cur.count >= min_count);
  assign recip_idx = (COUNT_W-1)'(cur.count - 7'd1);

  always_comb begin
    diff_max = diff_r;
    if (diff_g > diff_max) begin
      diff_max = diff_g;
    end
    if (diff_b > diff_max) begin
      diff_max = diff_b;
    end
  end

  // Channel sum that feeds the shared multiplier in each divide phase.
  always_comb begin
    unique case (phase)
      2'd0:    sum_sel = cur.sum_red;
      2'd1:    sum_sel = cur.sum_green;
      default: sum_sel = cur.sum_blue;
    endcase
  end

  assign prod_quot = prod[RECIP_SHIFT +: PIX_W];

  // Sequencer: store writes, results and next state.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = tile_q;
    mem_wdata  = cur;
    produce    = 1'b0;
    res_fg     = 1'b0;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_valid  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_q == CMD_FINALIZE && fin_ok) begin
          state_next = ST_DIV;
        end else if (out_free) begin
          produce    = 1'b1;
          state_next = ST_IDLE;
          unique case (cmd_q)
            CMD_CLEAR: begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
            CMD_ACCUMULATE: begin
              if (!masked_q && cur.count < COUNT_CAP) begin
                mem_we              = 1'b1;
                mem_wdata.sum_red   = cur.sum_red + SUM_W'(red_q);
                mem_wdata.sum_green = cur.sum_green + SUM_W'(green_q);
                mem_wdata.sum_blue  = cur.sum_blue + SUM_W'(blue_q);
                mem_wdata.count     = cur.count + 7'd1;
              end
            end
            CMD_FINALIZE: begin
              // Count too low: the tile keeps its sums and count but gets a zero mean and is invalid.
              mem_we               = 1'b1;
              mem_wdata.mean_red   = '0;
              mem_wdata.mean_green = '0;
              mem_wdata.mean_blue  = '0;
              mem_wdata.valid      = 1'b0;
            end
            CMD_CLASSIFY: begin
              res_fg    = (diff_max >= diff_threshold);
              res_red   = cur.mean_red;
              res_green = cur.mean_green;
              res_blue  = cur.mean_blue;
              res_valid = cur.valid;
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (phase == PHASE_LAST && out_free) begin
          mem_we               = 1'b1;
          mem_wdata.mean_red   = quot_red;
          mem_wdata.mean_green = quot_green;
          mem_wdata.mean_blue  = prod_quot;
          mem_wdata.valid      = 1'b1;
          produce              = 1'b1;
          res_red              = quot_red;
          res_green            = quot_green;
          res_blue             = prod_quot;
          res_valid            = 1'b1;
          state_next           = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + TILE_ADDR_W'(1);
      end
    end
  end

  // Divider: one channel product per phase, quotient taken the phase after.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (state == ST_EXEC) begin
      phase <= '0;
    end else if (state == ST_DIV && phase != PHASE_LAST) begin
      phase <= phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      recip_q <= RECIP[recip_idx];
    end
    if (state == ST_DIV && phase != PHASE_LAST) begin
      prod <= PROD_W'(sum_sel) * PROD_W'(recip_q);
      if (phase == 2'd1) begin
        quot_red <= prod_quot;
      end
      if (phase == 2'd2) begin
        quot_green <= prod_quot;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      foreground <= res_fg;
      mean_red   <= res_red;
      mean_green <= res_green;
      mean_blue  <= res_blue;
      tile_valid <= res_valid;
    end
  end

endmodule

>>> test/tcbm_checker.sv
// Scoreboard for the tile color background model: watches the request, result and
// configuration ports, predicts each result from its own tile store and compares.
// Depends on tcbm_pkg for widths, command codes and register indexes.
`timescale 1ns / 1ps

module tcbm_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       command,
  input  logic [tcbm_pkg::TILE_ADDR_W-1:0] tile_index,
  input  logic [tcbm_pkg::PIX_W-1:0]       red,
  input  logic [tcbm_pkg::PIX_W-1:0]       green,
  input  logic [tcbm_pkg::PIX_W-1:0]       blue,
  input  logic                             masked,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             foreground,
  input  logic [tcbm_pkg::PIX_W-1:0]       mean_red,
  input  logic [tcbm_pkg::PIX_W-1:0]       mean_green,
  input  logic [tcbm_pkg::PIX_W-1:0]       mean_blue,
  input  logic                             tile_valid,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [7:0]                       cfg_data,
  output int                               fail_count,
  output int                               pending
);

  import tcbm_pkg::*;

  typedef struct packed {
    logic             foreground;
    logic [PIX_W-1:0] mean_red;
    logic [PIX_W-1:0] mean_green;
    logic [PIX_W-1:0] mean_blue;
    logic             tile_valid;
  } tile_result_t;

  // Shadow copy of the tile store and of the two registers.
  logic [SUM_W-1:0]   shadow_sum   [TILE_COUNT][3];
  logic [COUNT_W-1:0] shadow_count [TILE_COUNT];
  logic [PIX_W-1:0]   shadow_mean  [TILE_COUNT][3];
  logic               shadow_valid [TILE_COUNT];
  logic [7:0]         threshold;
  logic [COUNT_W-1:0] min_pixels;

  // Results predicted for accepted requests, oldest first.
  tile_result_t expected_results[$];

  // Applies one request to the shadow store and returns the result it yields.
  function automatic tile_result_t apply_request(logic [1:0] cmd, logic [TILE_ADDR_W-1:0] t,
                                                 logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                                 logic [PIX_W-1:0] b, logic m);
    tile_result_t res;
    logic [PIX_W-1:0] px [3];
    int n;
    int worst;
    int delta;
    logic keep;
    res = '0;
    px[0] = r;
    px[1] = g;
    px[2] = b;
    case (cmd)
      CMD_CLEAR: begin
        for (int c = 0; c < 3; c++) begin
          shadow_sum[t][c]  = '0;
          shadow_mean[t][c] = '0;
        end
        shadow_count[t] = '0;
        shadow_valid[t] = 1'b0;
      end
      CMD_ACCUMULATE: begin
        // A full tile or a masked pixel leaves the entry alone.
        if (!m && shadow_count[t] < COUNT_CAP) begin
          for (int c = 0; c < 3; c++) shadow_sum[t][c] = shadow_sum[t][c] + SUM_W'(px[c]);
          shadow_count[t] = shadow_count[t] + COUNT_W'(1);
        end
      end
      CMD_FINALIZE: begin
        // An empty tile never gets a valid mean, whatever the minimum.
        n    = shadow_count[t];
        keep = (n != 0) && (n >= int'(min_pixels));
        for (int c = 0; c < 3; c++) begin
          if (keep) shadow_mean[t][c] = PIX_W'(int'(shadow_sum[t][c]) / n);
          else shadow_mean[t][c] = '0;
        end
        shadow_valid[t] = keep;
        res.mean_red    = shadow_mean[t][0];
        res.mean_green  = shadow_mean[t][1];
        res.mean_blue   = shadow_mean[t][2];
        res.tile_valid  = keep;
      end
      default: begin
        // Largest per-channel distance against the stored mean.
        worst = 0;
        for (int c = 0; c < 3; c++) begin
          delta = int'(px[c]) - int'(shadow_mean[t][c]);
          if (delta < 0) delta = -delta;
          if (delta > worst) worst = delta;
        end
        res.foreground = (worst >= int'(threshold));
        res.mean_red   = shadow_mean[t][0];
        res.mean_green = shadow_mean[t][1];
        res.mean_blue  = shadow_mean[t][2];
        res.tile_valid = shadow_valid[t];
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Compare delivered results first, then record the request taken at this edge.
  always @(posedge clk) begin
    tile_result_t want;
    if (rst) begin
      for (int i = 0; i < TILE_COUNT; i++) begin
        for (int c = 0; c < 3; c++) begin
          shadow_sum[i][c]  = '0;
          shadow_mean[i][c] = '0;
        end
        shadow_count[i] = '0;
        shadow_valid[i] = 1'b0;
      end
      threshold  = DIFF_THRESHOLD_RESET;
      min_pixels = MIN_COUNT_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result delivered with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("foreground", 8'(want.foreground), 8'(foreground));
          compare_field("mean_red", want.mean_red, mean_red);
          compare_field("mean_green", want.mean_green, mean_green);
          compare_field("mean_blue", want.mean_blue, mean_blue);
          compare_field("tile_valid", 8'(want.tile_valid), 8'(tile_valid));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(command, tile_index, red, green, blue,
                                                 masked));
      if (cfg_write) begin
        case (cfg_index)
          CFG_DIFF_THRESHOLD: threshold = cfg_data;
          CFG_MIN_COUNT:      min_pixels = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> test/tb_tile_color_background_model_unit.sv
// Testbench top for tile_color_background_model_unit: clock, reset, request and
// configuration stimulus, result back-pressure and the verdict.
// Depends on tcbm_pkg, the block itself and tcbm_checker.
`timescale 1ns / 1ps

module tb_tile_color_background_model_unit;
  import tcbm_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             command = CMD_CLEAR;
  logic [TILE_ADDR_W-1:0] tile_index = '0;
  logic [PIX_W-1:0]       red = '0;
  logic [PIX_W-1:0]       green = '0;
  logic [PIX_W-1:0]       blue = '0;
  logic                   masked = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   foreground;
  logic [PIX_W-1:0]       mean_red;
  logic [PIX_W-1:0]       mean_green;
  logic [PIX_W-1:0]       mean_blue;
  logic                   tile_valid;
  logic                   cfg_write = 1'b0;
  logic                   cfg_index = CFG_DIFF_THRESHOLD;
  logic [7:0]             cfg_data = '0;

  int fail_count;
  int pending;

  // Shared knobs between the request driver and the result receiver.
  int   gap_pct = 0;
  int   stall_pct = 0;
  bit   hold_off_request = 1'b0;
  int   requests_sent = 0;
  int   cmd_seen [4] = '{0, 0, 0, 0};
  int   settings_used = 0;
  logic [TILE_ADDR_W-1:0] tile_pool [16];

  always #10 clk = ~clk;

  tile_color_background_model_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .tile_index (tile_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .masked     (masked),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .foreground (foreground),
    .mean_red   (mean_red),
    .mean_green (mean_green),
    .mean_blue  (mean_blue),
    .tile_valid (tile_valid),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tcbm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .tile_index (tile_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .masked     (masked),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .foreground (foreground),
    .mean_red   (mean_red),
    .mean_green (mean_green),
    .mean_blue  (mean_blue),
    .tile_valid (tile_valid),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offers one request, with an optional idle burst first, and waits for acceptance.
  task automatic send_request(logic [1:0] cmd, logic [TILE_ADDR_W-1:0] t,
                              logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] b, logic m);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    tile_index <= t;
    red        <= r;
    green      <= g;
    blue       <= b;
    masked     <= m;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    cmd_seen[cmd]++;
  endtask

  // Lets the block drain, then writes both registers.
  task automatic set_config(logic [7:0] thr, logic [COUNT_W-1:0] minc);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DIFF_THRESHOLD;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_index <= CFG_MIN_COUNT;
    cfg_data  <= {1'b0, minc};
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // A shade near the base color, clamped to the channel range.
  function automatic logic [PIX_W-1:0] near_shade(logic [PIX_W-1:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // One tile's life: usually a clear, a run of pixels, usually a finalize and a few probes.
  // A small share of calls sends a single random request instead.
  task automatic run_tile_sequence();
    logic [TILE_ADDR_W-1:0] t;
    logic [PIX_W-1:0] base_r;
    logic [PIX_W-1:0] base_g;
    logic [PIX_W-1:0] base_b;
    int n_pix;
    int n_probe;
    int spread;
    if ($urandom_range(0, 99) < 8) begin
      send_request(2'($urandom_range(0, 3)), TILE_ADDR_W'($urandom), PIX_W'($urandom),
                   PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
      return;
    end
    t = ($urandom_range(0, 99) < 70) ? tile_pool[$urandom_range(0, 15)]
                                     : TILE_ADDR_W'($urandom);
    base_r = PIX_W'($urandom);
    base_g = PIX_W'($urandom);
    base_b = PIX_W'($urandom);
    spread = $urandom_range(0, 20);
    if ($urandom_range(0, 99) < 85)
      send_request(CMD_CLEAR, t, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                   1'($urandom));
    // Mostly short runs; some long enough to fill the tile.
    n_pix = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 40) : $urandom_range(55, 72);
    repeat (n_pix) begin
      if ($urandom_range(0, 99) < 10)
        send_request(CMD_ACCUMULATE, t, PIX_W'($urandom), PIX_W'($urandom),
                     PIX_W'($urandom), 1'($urandom));
      else
        send_request(CMD_ACCUMULATE, t, near_shade(base_r, spread), near_shade(base_g, spread),
                     near_shade(base_b, spread), ($urandom_range(0, 99) < 8));
    end
    if ($urandom_range(0, 99) < 90)
      send_request(CMD_FINALIZE, t, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                   1'($urandom));
    n_probe = $urandom_range(1, 6);
    repeat (n_probe) begin
      spread = $urandom_range(0, 60);
      send_request(CMD_CLASSIFY, t, near_shade(base_r, spread), near_shade(base_g, spread),
                   near_shade(base_b, spread), 1'($urandom));
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_request = 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit, far beyond the slowest correct run including the clearing pass.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int phase_goal;
    logic [7:0] thr;
    logic [COUNT_W-1:0] minc;
    tile_pool[0] = '0;
    tile_pool[1] = '1;
    for (int i = 2; i < 16; i++) tile_pool[i] = TILE_ADDR_W'($urandom);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed checks under the reset settings: extremes, an empty tile,
    // a masked pixel and a tile that stays below the minimum count.
    send_request(CMD_CLASSIFY, '0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(CMD_CLASSIFY, '1, 8'd255, 8'd255, 8'd255, 1'b1);
    send_request(CMD_FINALIZE, 12'd5, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(CMD_CLEAR, 12'd7, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(CMD_ACCUMULATE, 12'd7, 8'd255, 8'd0, 8'd128, 1'b0);
    send_request(CMD_ACCUMULATE, 12'd7, 8'd255, 8'd255, 8'd255, 1'b1);
    send_request(CMD_FINALIZE, 12'd7, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(CMD_CLASSIFY, 12'd7, 8'd255, 8'd0, 8'd128, 1'b0);

    // Largest threshold and a zero minimum: a truncating mean, and an empty
    // tile that still stays invalid.
    set_config(8'd255, 7'd0);
    send_request(CMD_ACCUMULATE, 12'd9, 8'd255, 8'd255, 8'd255, 1'b0);
    send_request(CMD_ACCUMULATE, 12'd9, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(CMD_ACCUMULATE, 12'd9, 8'd1, 8'd2, 8'd3, 1'b0);
    send_request(CMD_FINALIZE, 12'd9, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(CMD_CLASSIFY, 12'd9, 8'd255, 8'd0, 8'd0, 1'b0);
    send_request(CMD_FINALIZE, 12'd5, 8'd0, 8'd0, 8'd0, 1'b0);

    // Difference exactly at the threshold, then a zero threshold.
    set_config(8'd170, 7'd0);
    send_request(CMD_CLASSIFY, 12'd9, 8'd255, 8'd85, 8'd86, 1'b0);
    send_request(CMD_CLASSIFY, 12'd9, 8'd254, 8'd85, 8'd86, 1'b0);
    send_request(CMD_CLEAR, 12'd9, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(CMD_CLASSIFY, 12'd9, 8'd0, 8'd0, 8'd0, 1'b0);
    set_config(8'd0, 7'd127);
    send_request(CMD_CLASSIFY, '1, 8'd0, 8'd0, 8'd0, 1'b0);

    // Random phases, each under its own settings; the last one runs without idling.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin thr = DIFF_THRESHOLD_RESET; minc = MIN_COUNT_RESET; end
        1:       begin thr = 8'd0;   minc = 7'd1;   end
        2:       begin thr = 8'd255; minc = 7'd64;  end
        3:       begin thr = 8'($urandom); minc = COUNT_W'($urandom_range(0, 127)); end
        4:       begin thr = 8'd128; minc = 7'd65;  end
        default: begin thr = 8'($urandom_range(4, 60)); minc = COUNT_W'($urandom_range(1, 40)); end
      endcase
      set_config(thr, minc);
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 30; stall_pct = 30; end
        2:       begin gap_pct = 10; stall_pct = 40; end
        3:       begin gap_pct = 40; stall_pct = 10; end
        4:       begin gap_pct = 20; stall_pct = 20; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      // Fill the block against a stalled receiver once.
      if (phase == 1) hold_off_request = 1'b1;
      phase_goal = requests_sent + 180;
      while (requests_sent < phase_goal) run_tile_sequence();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Run covered %0d requests: %0d clear, %0d accumulate, %0d finalize, %0d classify.",
             requests_sent, cmd_seen[CMD_CLEAR], cmd_seen[CMD_ACCUMULATE],
             cmd_seen[CMD_FINALIZE], cmd_seen[CMD_CLASSIFY]);
    $display("Register settings applied: %0d; one result-side hold-off of %0d cycles.",
             settings_used, HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
